@@ src/bsel_pkg.sv @@
`default_nettype none
package bsel_pkg;
	localparam int MAX_SLOTS_DEF = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int SLOT_W = 4;
	localparam int WEIGHT_W = 16;
	localparam int IP_W = 32;

	typedef enum logic [2:0] {
		K_SELECT = 3'd0, K_SELECT_IP = 3'd1, K_OPEN = 3'd2, K_CLOSE = 3'd3,
		K_ADD = 3'd4, K_SET_READY = 3'd5, K_SET_WEIGHT = 3'd6, K_UNUSED = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NONE_READY = 2'd1, ST_FULL = 2'd2, ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		M_ROUND = 2'd0, M_LEAST = 2'd1, M_GPU = 2'd2, M_ROUND_ALT = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_COUNT, S_DIV, S_PICK, S_SCAN, S_READ, S_UPDATE, S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [IP_W-1:0] peer_addr;
		logic [SLOT_W-1:0] backend_slot;
		logic ready_value;
		logic [WEIGHT_W-1:0] weight_value;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic [1:0] status;
	} resp_t;
endpackage
`default_nettype wire

@@ src/bsel_if.sv @@
`default_nettype none
interface bsel_req_if;
	import bsel_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/bsel_resp_if.sv @@
`default_nettype none
interface bsel_resp_if;
	import bsel_pkg::*;
	logic valid;
	logic ready;
	resp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/bsel_cfg_if.sv @@
`default_nettype none
interface bsel_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] select_mode;
	modport source(output valid, output select_mode, input ready);
	modport sink(input valid, input select_mode, output ready);
endinterface
`default_nettype wire

@@ src/backend_selector.sv @@
// backend_selector: picks a backend slot from a table of up to MAX_SLOTS slots.
// Channels: req (sink) carries one request with kind, peer_addr, backend_slot,
// ready_value and weight_value; resp (source) returns chosen_slot and status;
// cfg (sink) writes the select_mode register; the user must write it only
// while the block is idle, which the block itself does not enforce. Every
// request produces exactly one response. A sequencer walks the slot table
// one slot per cycle and runs a one-bit-per-cycle restoring divider for the
// modulo by the ready count. A client-IP select hashes the peer address,
// counts the ready slots, divides, locates the chosen ready slot and loads
// the response register. Round robin skips the hash; least connections and
// GPU-aware scan the table for the best ready slot instead of dividing; a
// select with no ready slot goes to the response after the count; table
// updates read the addressed slot and then update it. req.ready is high
// only in the idle state, so a new request is taken only after the previous
// response has been loaded into the response register.
// Reset clears the slot count, all ready flags, the rotation counter, the mode
// and the response register. When the receiver stalls, the response waits in
// its register while the next request is processed; that one then waits in
// the sequencer, which takes no new request until the register is free.
`default_nettype none
module backend_selector #(
	parameter int MAX_SLOTS = bsel_pkg::MAX_SLOTS_DEF,
	parameter int COUNT_BITS = bsel_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bsel_req_if.sink req,
	bsel_resp_if.source resp,
	bsel_cfg_if.sink cfg
);
	import bsel_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	state_t state_q, state_d;
	logic [1:0] mode_q;
	logic [CNT_W-1:0] slot_count_q;
	logic [MAX_SLOTS-1:0] ready_q;
	logic [COUNT_BITS-1:0] conn_mem [MAX_SLOTS];
	logic [WEIGHT_W-1:0] weight_mem [MAX_SLOTS];
	logic [31:0] rot_q;

	req_t req_q;
	logic [31:0] dividend_q;   // hash or rotation value, then shifted in the divider
	logic [CNT_W-1:0] rem_q;
	logic [5:0] step_q;        // digit index or divide bit index
	logic [CNT_W-1:0] idx_q;   // scan position, width holds MAX_SLOTS
	logic [CNT_W-1:0] nready_q;
	logic [CNT_W-1:0] seen_q;
	logic have_q;
	logic [COUNT_BITS-1:0] best_conn_q;
	logic [WEIGHT_W-1:0] best_w_q;
	logic [SLOT_W-1:0] chosen_q;
	logic [1:0] status_q;
	logic [COUNT_BITS-1:0] rd_conn_q;
	logic out_valid_q;
	resp_t out_q;

	logic accept;
	logic out_load;
	logic [IDX_W-1:0] idx_cur;
	logic in_range;
	logic [7:0] octet;
	logic [3:0] digit;
	logic digit_use;
	logic [CNT_W:0] rem_try;
	logic [IDX_W-1:0] slot_idx;
	logic slot_ok;

	assign accept = req.valid && req.ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || resp.ready);
	assign idx_cur = idx_q[IDX_W-1:0];
	assign in_range = idx_q < slot_count_q;
	assign slot_idx = IDX_W'(req_q.backend_slot);
	assign slot_ok = (32'(req_q.backend_slot) < 32'(slot_count_q))
		&& (32'(req_q.backend_slot) < 32'(MAX_SLOTS));

	// Hash digit walk: step_q counts 16 positions, 4 per octet, of which the first
	// 3 are digit positions. The decimal digits come from compares against multiples of 100 and 10.
	always_comb begin
		logic [1:0] oi;
		logic [1:0] pos;
		logic [1:0] hund;
		logic [7:0] rem1;
		logic [3:0] tens;
		logic [3:0] ones;
		oi = step_q[3:2];
		pos = step_q[1:0];
		octet = req_q.peer_addr[8*(3-oi) +: 8];
		if (octet >= 8'd200) begin
			hund = 2'd2;
			rem1 = octet - 8'd200;
		end else if (octet >= 8'd100) begin
			hund = 2'd1;
			rem1 = octet - 8'd100;
		end else begin
			hund = 2'd0;
			rem1 = octet;
		end
		tens = '0;
		for (int k = 1; k < 10; k++)
			if (rem1 >= 8'(10 * k)) tens = 4'(k);
		ones = 4'(rem1 - 8'(tens) * 8'd10);
		digit = '0;
		digit_use = 1'b0;
		case (pos)
			2'd0: begin
				digit = 4'(hund);
				digit_use = octet >= 8'd100;
			end
			2'd1: begin
				digit = tens;
				digit_use = octet >= 8'd10;
			end
			2'd2: begin
				digit = ones;
				digit_use = 1'b1;
			end
			default: begin
				digit = '0;
				digit_use = 1'b0;
			end
		endcase
	end

	assign rem_try = {rem_q, dividend_q[31]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) begin
				if (req.payload.kind == K_SELECT_IP) state_d = S_HASH;
				else if (req.payload.kind == K_SELECT) state_d = S_COUNT;
				else state_d = S_READ;
			end
			S_HASH: if (step_q == 6'd15) state_d = S_COUNT;
			S_COUNT: if (idx_q == CNT_W'(MAX_SLOTS)) begin
				if (nready_q == '0) state_d = S_DONE;
				else if (req_q.kind == K_SELECT && (mode_q == M_LEAST || mode_q == M_GPU))
					state_d = S_SCAN;
				else state_d = S_DIV;
			end
			S_DIV: if (step_q == 6'd31) state_d = S_PICK;
			S_PICK: if (idx_q == CNT_W'(MAX_SLOTS)) state_d = S_DONE;
			S_SCAN: if (idx_q == CNT_W'(MAX_SLOTS)) state_d = S_DONE;
			S_READ: state_d = S_UPDATE;
			S_UPDATE: state_d = S_DONE;
			S_DONE: if (!out_valid_q || resp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		cfg.ready = 1'b1;
		resp.valid = out_valid_q;
		resp.payload.chosen_slot = out_q.chosen_slot;
		resp.payload.status = out_q.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_ROUND;
			slot_count_q <= '0;
			ready_q <= '0;
			rot_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) mode_q <= cfg.select_mode;
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q.chosen_slot <= chosen_q;
				out_q.status <= status_q;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_COUNT && idx_q == CNT_W'(MAX_SLOTS) && nready_q != '0
					&& req_q.kind == K_SELECT && mode_q != M_LEAST && mode_q != M_GPU)
				rot_q <= rot_q + 32'd1;
			if (state_q == S_UPDATE) begin
				if (req_q.kind == K_ADD && slot_count_q < CNT_W'(MAX_SLOTS)) begin
					ready_q[slot_count_q[IDX_W-1:0]] <= 1'b0;
					slot_count_q <= slot_count_q + CNT_W'(1);
				end
				if (req_q.kind == K_SET_READY && slot_ok)
					ready_q[slot_idx] <= req_q.ready_value;
			end
		end
	end

	// Table memories and datapath registers. The connection count of the
	// addressed slot is read in S_READ and written back in S_UPDATE.
	always_ff @(posedge clk) begin
		rd_conn_q <= conn_mem[slot_idx];
		case (state_q)
			S_IDLE: begin
				req_q <= req.payload;
				dividend_q <= '0;
				step_q <= '0;
				idx_q <= '0;
				nready_q <= '0;
			end
			S_HASH: begin
				if (step_q[1:0] != 2'd3 && digit_use)
					dividend_q <= dividend_q * 32'd10 + 32'(digit);
				step_q <= step_q + 6'd1;
				if (step_q == 6'd15) idx_q <= '0;
			end
			S_COUNT: begin
				if (idx_q != CNT_W'(MAX_SLOTS)) begin
					if (in_range && ready_q[idx_cur]) nready_q <= nready_q + CNT_W'(1);
					idx_q <= idx_q + CNT_W'(1);
				end else begin
					idx_q <= '0;
					step_q <= '0;
					rem_q <= '0;
					have_q <= 1'b0;
					seen_q <= '0;
					if (req_q.kind == K_SELECT) dividend_q <= rot_q;
					chosen_q <= '0;
					status_q <= (nready_q == '0) ? ST_NONE_READY : ST_OK;
				end
			end
			S_DIV: begin
				if (rem_try >= {1'b0, nready_q}) rem_q <= CNT_W'(rem_try - {1'b0, nready_q});
				else rem_q <= rem_try[CNT_W-1:0];
				dividend_q <= {dividend_q[30:0], 1'b0};
				step_q <= step_q + 6'd1;
			end
			S_PICK: begin
				if (idx_q != CNT_W'(MAX_SLOTS)) begin
					if (in_range && ready_q[idx_cur]) begin
						if (seen_q == rem_q) chosen_q <= SLOT_W'(idx_q);
						seen_q <= seen_q + CNT_W'(1);
					end
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_SCAN: begin
				if (idx_q != CNT_W'(MAX_SLOTS)) begin
					if (in_range && ready_q[idx_cur]) begin
						if (!have_q || (mode_q == M_LEAST && conn_mem[idx_cur] < best_conn_q)
								|| (mode_q == M_GPU && weight_mem[idx_cur] > best_w_q)) begin
							have_q <= 1'b1;
							best_conn_q <= conn_mem[idx_cur];
							best_w_q <= weight_mem[idx_cur];
							chosen_q <= SLOT_W'(idx_q);
						end
					end
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_UPDATE: begin
				case (req_q.kind)
					K_ADD: begin
						if (slot_count_q >= CNT_W'(MAX_SLOTS)) begin
							chosen_q <= '0;
							status_q <= ST_FULL;
						end else begin
							chosen_q <= SLOT_W'(slot_count_q);
							status_q <= ST_OK;
							conn_mem[slot_count_q[IDX_W-1:0]] <= '0;
							weight_mem[slot_count_q[IDX_W-1:0]] <= '0;
						end
					end
					K_OPEN, K_CLOSE, K_SET_READY, K_SET_WEIGHT: begin
						if (!slot_ok) begin
							chosen_q <= '0;
							status_q <= ST_ABSENT;
						end else begin
							chosen_q <= req_q.backend_slot;
							status_q <= ST_OK;
							if (req_q.kind == K_OPEN && rd_conn_q != {COUNT_BITS{1'b1}})
								conn_mem[slot_idx] <= rd_conn_q + COUNT_BITS'(1);
							else if (req_q.kind == K_CLOSE && rd_conn_q != '0)
								conn_mem[slot_idx] <= rd_conn_q - COUNT_BITS'(1);
							if (req_q.kind == K_SET_WEIGHT)
								weight_mem[slot_idx] <= req_q.weight_value;
						end
					end
					default: begin
						chosen_q <= '0;
						status_q <= ST_OK;
					end
				endcase
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
